### hdl/utf16_to_utf32_stream_decoder_defines.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-32 decoder assertion macros
// Shared property wrappers for the concurrent checks of the decoder.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF32_STREAM_DECODER_DEFINES_SVH
`define UTF16_TO_UTF32_STREAM_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U16U32_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U16U32_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/u16u32_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-32 decoder package
// Job format and queue sizing shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
package u16u32_pkg;

  localparam int unsigned CpW    = 21;  // widest code point is 0x10FFFF
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam logic [CpW-1:0] BomWord     = CpW'(32'h0000_FEFF);
  localparam logic [15:0]    HiSurLo     = 16'hD800;
  localparam logic [15:0]    HiSurHi     = 16'hDBFF;
  localparam logic [15:0]    LoSurLo     = 16'hDC00;
  localparam logic [15:0]    LoSurHi     = 16'hDFFF;
  localparam logic [CpW-1:0] SupplOffset = CpW'(32'h0001_0000);
  localparam logic [7:0]     MarkFe      = 8'hFE;
  localparam logic [7:0]     MarkFf      = 8'hFF;

  // One unit of work for the back end: a code point to serialize or an error.
  typedef struct packed {
    logic           err;
    logic           big;
    logic [CpW-1:0] word;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

endpackage

### hdl/u16u32_in_if.sv
// ----------------------------------------------------------------------------
// UTF-16 byte channel
// Valid/ready channel that carries one raw byte and the stream start flag.
// ----------------------------------------------------------------------------
interface u16u32_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink   (input valid, input in_byte, input stream_start, output ready);
endinterface

### hdl/u16u32_out_if.sv
// ----------------------------------------------------------------------------
// UTF-32 byte channel
// Valid/ready channel that carries one output byte with its run and error flags.
// ----------------------------------------------------------------------------
interface u16u32_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       bad_mark;

  modport source (output valid, output out_byte, output last_of_run, output bad_mark,
                  input ready);
  modport sink   (input valid, input out_byte, input last_of_run, input bad_mark,
                  output ready);
endinterface

### hdl/u16u32_front.sv
// ----------------------------------------------------------------------------
// UTF-16 decoder front end
// Accepts bytes, tracks the mark and surrogate phases and issues jobs.
// ----------------------------------------------------------------------------
module u16u32_front
  import u16u32_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       stream_start_i,
  output logic       ready_o,
  input  logic       q_full_i,
  output q_wr_t      q_wr_o
);

  localparam logic [2:0] PhMark0  = 3'd0;
  localparam logic [2:0] PhMark1  = 3'd1;
  localparam logic [2:0] PhUnit0  = 3'd2;
  localparam logic [2:0] PhUnit1  = 3'd3;
  localparam logic [2:0] PhLow0   = 3'd4;
  localparam logic [2:0] PhLow1   = 3'd5;
  localparam logic [2:0] PhSilent = 3'd6;

  logic [2:0] phase_q, phase_d;
  logic       big_q, big_d;
  logic [7:0] held_q, held_d;
  logic [9:0] hs_q, hs_d;

  logic        accept;
  logic [2:0]  ph;
  logic        big_cur;
  logic [9:0]  hs_cur;
  logic [15:0] unit;
  logic [15:0] unit_off;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;

  // A start flag restarts decoding with this byte as the first mark byte.
  assign ph      = stream_start_i ? PhMark0 : phase_q;
  assign big_cur = stream_start_i ? 1'b0 : big_q;
  assign hs_cur  = stream_start_i ? 10'd0 : hs_q;
  assign unit    = big_cur ? {held_q, in_byte_i} : {in_byte_i, held_q};

  always_comb begin
    phase_d       = phase_q;
    big_d         = big_q;
    held_d        = held_q;
    hs_d          = hs_q;
    unit_off      = '0;
    q_wr_o.push   = 1'b0;
    q_wr_o.job    = '{err: 1'b0, big: big_cur, word: CpW'(unit)};
    if (accept) begin
      phase_d = ph;
      big_d   = big_cur;
      hs_d    = hs_cur;
      unique case (ph)
        PhMark0: begin
          held_d  = in_byte_i;
          phase_d = PhMark1;
        end
        PhMark1: begin
          q_wr_o.push = 1'b1;
          if (held_q == MarkFe && in_byte_i == MarkFf) begin
            big_d      = 1'b1;
            phase_d    = PhUnit0;
            q_wr_o.job = '{err: 1'b0, big: 1'b1, word: BomWord};
          end else if (held_q == MarkFf && in_byte_i == MarkFe) begin
            big_d      = 1'b0;
            phase_d    = PhUnit0;
            q_wr_o.job = '{err: 1'b0, big: 1'b0, word: BomWord};
          end else begin
            phase_d    = PhSilent;
            q_wr_o.job = '{err: 1'b1, big: big_cur, word: '0};
          end
        end
        PhUnit0, PhLow0: begin
          held_d  = in_byte_i;
          phase_d = ph + 3'd1;
        end
        PhUnit1: begin
          if (unit >= HiSurLo && unit <= HiSurHi) begin
            unit_off = unit - HiSurLo;
            hs_d     = unit_off[9:0];
            phase_d  = PhLow0;
          end else begin
            phase_d     = PhUnit0;
            q_wr_o.push = 1'b1;
          end
        end
        PhLow1: begin
          phase_d = PhUnit0;
          if (unit >= LoSurLo && unit <= LoSurHi) begin
            unit_off        = unit - LoSurLo;
            q_wr_o.push     = 1'b1;
            q_wr_o.job.word = {1'b0, hs_cur, unit_off[9:0]} + SupplOffset;
          end
        end
        default: phase_d = PhSilent;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhMark0;
      big_q   <= 1'b0;
      held_q  <= '0;
      hs_q    <= '0;
    end else begin
      phase_q <= phase_d;
      big_q   <= big_d;
      held_q  <= held_d;
      hs_q    <= hs_d;
    end
  end

endmodule

### hdl/u16u32_queue.sv
// ----------------------------------------------------------------------------
// UTF-16 decoder job queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module u16u32_queue
  import u16u32_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t wr_i,
  output logic  full_o,
  output q_rd_t rd_o,
  input  logic  pop_i
);

  job_t           mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCw-1:0] cnt_q;
  logic           do_push, do_pop;

  assign full_o     = (cnt_q == QCw'(QDepth));
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.job   = mem_q[rd_ptr_q];
  assign do_push    = wr_i.push && !full_o;
  assign do_pop     = pop_i && rd_o.valid;

  function automatic logic [QAw-1:0] next_ptr(input logic [QAw-1:0] p);
    return (p == QAw'(QDepth - 1)) ? '0 : p + QAw'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCw'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCw'(1);
      end
    end
  end

endmodule

### hdl/u16u32_back.sv
// ----------------------------------------------------------------------------
// UTF-16 decoder back end
// Serializes each job into UTF-32 bytes through a registered output stage.
// ----------------------------------------------------------------------------
module u16u32_back
  import u16u32_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_rd_t      rd_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       bad_mark_o
);

  logic        valid_q;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        bad_q;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  idx;
  logic [31:0] word32;
  logic        load;

  assign load   = rd_i.valid && (!valid_q || ready_i);
  assign word32 = {{(32 - CpW){1'b0}}, rd_i.job.word};
  // Byte k of a word goes out most significant first in big endian order.
  assign idx    = rd_i.job.big ? (2'd3 - cnt_q) : cnt_q;

  always_comb begin
    unique case (idx)
      2'd0:    byte_d = word32[7:0];
      2'd1:    byte_d = word32[15:8];
      2'd2:    byte_d = word32[23:16];
      default: byte_d = word32[31:24];
    endcase
    if (rd_i.job.err) begin
      byte_d = '0;
    end
    last_d = rd_i.job.err || (cnt_q == 2'd3);
    cnt_d  = last_d ? 2'd0 : cnt_q + 2'd1;
  end

  assign pop_o = load && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        cnt_q   <= cnt_d;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      last_q <= last_d;
      bad_q  <= rd_i.job.err;
    end
  end

  assign valid_o       = valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;
  assign bad_mark_o    = bad_q;

endmodule

### hdl/utf16_to_utf32_stream_decoder.sv
// Path: a job is written into the queue on the transfer edge and moves into the output
//   register once that is free; its first byte is then valid.
// Throughput: one input transfer per cycle while the two-entry job queue has
//   room; the sustained rate is limited by the back end's single byte-wide
//   output register, which emits four bytes per code point.
// Reset: rst_ni (asynchronous, active low) clears queue and output; decoding awaits a mark.
// ----------------------------------------------------------------------------
// UTF-16 to UTF-32 stream decoder
// Converts a byte-serial UTF-16 stream with byte order mark into UTF-32 bytes.
// ----------------------------------------------------------------------------
`include "utf16_to_utf32_stream_decoder_defines.svh"

module utf16_to_utf32_stream_decoder
  import u16u32_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  u16u32_in_if.sink         in_i,
  u16u32_out_if.source      out_o
);

  // The front end decodes the byte order mark, pairs bytes into code units and
  // merges surrogate pairs. Every input byte yields at most one job, either a
  // code point to send or a bad mark error, which it pushes into the queue.
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  u16u32_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_i.valid),
    .in_byte_i      (in_i.in_byte),
    .stream_start_i (in_i.stream_start),
    .ready_o        (in_i.ready),
    .q_full_i       (q_full),
    .q_wr_o         (q_wr)
  );

  // The queue lets the front end keep taking transfers while the back end is
  // still working through an earlier code point or is stalled downstream.
  u16u32_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .full_o (q_full),
    .rd_o   (q_rd),
    .pop_i  (q_pop)
  );

  // The back end turns a job into four bytes in the stream's byte order, or a
  // single zero byte flagged as a bad mark, and releases the job on the last.
  u16u32_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rd_i          (q_rd),
    .pop_o         (q_pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .last_of_run_o (out_o.last_of_run),
    .bad_mark_o    (out_o.bad_mark)
  );

  // An error result is always a single zero byte that closes its run.
  `U16U32_ASSERT_SAME(a_bad_is_last, out_o.valid && out_o.bad_mark,
                      out_o.last_of_run && out_o.out_byte == 8'd0,
                      "bad mark result is not a lone zero byte")

  // The front end never issues a job into a full queue.
  `U16U32_ASSERT_SAME(a_no_push_full, q_full, !q_wr.push, "job pushed into full queue")

  // A waiting job with a free output stage is loaded at the next edge.
  `U16U32_ASSERT_NEXT(a_back_loads, q_rd.valid && (!out_o.valid || out_o.ready),
                      out_o.valid, "back end failed to load a waiting job")

endmodule

### dv/utf16_to_utf32_stream_decoder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-32 decoder checker
// Watches both byte channels, predicts the UTF-32 bytes of every UTF-16 byte
// transfer and compares them, in order, with the bytes the decoder sends.
// ----------------------------------------------------------------------------
module utf16_to_utf32_stream_decoder_checker
  import u16u32_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  u16u32_in_if  in_mon,
  u16u32_out_if out_mon,
  output int    fails_o,
  output int    pending_o,
  output int    results_o,
  output int    pairs_o,
  output int    bad_marks_o
);

  typedef enum logic [2:0] {
    MARK_FIRST,
    MARK_SECOND,
    UNIT_FIRST,
    UNIT_SECOND,
    LOW_FIRST,
    LOW_SECOND,
    SILENCED
  } dec_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } utf32_byte_t;

  localparam logic [31:0] Utf32Bom     = 32'h0000_FEFF;
  localparam logic [31:0] PlaneOneBase = 32'h0001_0000;

  dec_phase_e  phase_q;
  logic        big_q;
  logic [7:0]  held_q;
  logic [9:0]  hi_bits_q;
  utf32_byte_t utf32_bytes_q[$];
  utf32_byte_t want;

  task automatic report_mismatch(input string msg);
    fails_o++;
    $display("%0t checker: %s", $time, msg);
  endtask

  // A code point leaves as four bytes in the byte order of the stream.
  task automatic queue_code_point(input logic [31:0] cp);
    int sh;
    for (int k = 0; k < 4; k++) begin
      sh = big_q ? 24 - 8 * k : 8 * k;
      utf32_bytes_q.push_back('{data: 8'(cp >> sh), last: (k == 3), bad: 1'b0});
    end
  endtask

  task automatic decode_utf16_byte(input logic [7:0] b, input logic start);
    logic [15:0] unit;
    if (start) begin
      phase_q   = MARK_FIRST;
      big_q     = 1'b0;
      held_q    = 8'h00;
      hi_bits_q = 10'h000;
    end
    unit = big_q ? {held_q, b} : {b, held_q};
    case (phase_q)
      MARK_FIRST: begin
        held_q  = b;
        phase_q = MARK_SECOND;
      end
      MARK_SECOND: begin
        if (held_q == MarkFe && b == MarkFf) begin
          big_q   = 1'b1;
          phase_q = UNIT_FIRST;
          queue_code_point(Utf32Bom);
        end else if (held_q == MarkFf && b == MarkFe) begin
          big_q   = 1'b0;
          phase_q = UNIT_FIRST;
          queue_code_point(Utf32Bom);
        end else begin
          phase_q = SILENCED;
          utf32_bytes_q.push_back('{data: 8'h00, last: 1'b1, bad: 1'b1});
          bad_marks_o++;
        end
      end
      UNIT_FIRST: begin
        held_q  = b;
        phase_q = UNIT_SECOND;
      end
      LOW_FIRST: begin
        held_q  = b;
        phase_q = LOW_SECOND;
      end
      UNIT_SECOND: begin
        if (unit >= HiSurLo && unit <= HiSurHi) begin
          hi_bits_q = unit[9:0];
          phase_q   = LOW_FIRST;
        end else begin
          phase_q = UNIT_FIRST;
          queue_code_point({16'h0000, unit});
        end
      end
      LOW_SECOND: begin
        // Anything but a low surrogate here drops the pending pair silently.
        phase_q = UNIT_FIRST;
        if (unit >= LoSurLo && unit <= LoSurHi) begin
          queue_code_point(32'({hi_bits_q, unit[9:0]}) + PlaneOneBase);
          pairs_o++;
        end
      end
      default: phase_q = SILENCED;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     = MARK_FIRST;
      big_q       = 1'b0;
      held_q      = 8'h00;
      hi_bits_q   = 10'h000;
      fails_o     = 0;
      results_o   = 0;
      pairs_o     = 0;
      bad_marks_o = 0;
      utf32_bytes_q.delete();
      pending_o <= 0;
    end else begin
      // Results are compared before the same edge's input is decoded, so an
      // early byte cannot be matched against its own prediction.
      if (out_mon.valid && out_mon.ready) begin
        if (utf32_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected UTF-32 byte 0x%02h", out_mon.out_byte));
        end else begin
          want = utf32_bytes_q.pop_front();
          results_o++;
          if (out_mon.out_byte !== want.data)
            report_mismatch($sformatf("out_byte expected 0x%02h, got 0x%02h",
                                      want.data, out_mon.out_byte));
          if (out_mon.last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run expected %0b, got %0b",
                                      want.last, out_mon.last_of_run));
          if (out_mon.bad_mark !== want.bad)
            report_mismatch($sformatf("bad_mark expected %0b, got %0b",
                                      want.bad, out_mon.bad_mark));
        end
      end
      if (in_mon.valid && in_mon.ready)
        decode_utf16_byte(in_mon.in_byte, in_mon.stream_start);
      pending_o <= utf32_bytes_q.size();
    end
  end

endmodule

### dv/utf16_to_utf32_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-32 decoder testbench
// Drives directed and random UTF-16 byte streams into the decoder with random
// idling on both channels; a checker beside the decoder predicts and compares
// every UTF-32 byte, and this module gives the verdict.
// ----------------------------------------------------------------------------
module utf16_to_utf32_stream_decoder_tb;
  import u16u32_pkg::*;

  // Number of counted random UTF-16 bytes after the directed part.
  localparam int RandomItems = 500;
  // The final stretch of the random part runs without any idling.
  localparam int CalmTail    = 60;
  // Cycle limit for the watchdog on the whole run.
  localparam int CycleLimit  = 400000;
  // Margin after the drain that catches late extra bytes.
  localparam int DrainCycles = 12;

  // Directed part: bit 8 is the stream start flag, bits 7:0 the byte.
  // The first stream begins at reset without a start flag, in big endian, and
  // walks the smallest and largest plain units, the smallest surrogate pair,
  // a lone low surrogate, a high surrogate followed by a plain unit and an odd
  // trailing byte. A little endian stream then joins the largest surrogate
  // pair, and a last stream carries a bad mark followed by a silenced byte.
  localparam logic [8:0] DirectedSeq [26] = '{
    9'h0FE, 9'h0FF,
    9'h000, 9'h000,
    9'h0FF, 9'h0FF,
    9'h0D8, 9'h000, 9'h0DC, 9'h000,
    9'h0DC, 9'h000,
    9'h0D8, 9'h000, 9'h000, 9'h041,
    9'h07A,
    9'h1FF, 9'h0FE,
    9'h0FF, 9'h0DB, 9'h0FF, 9'h0DF,
    9'h1FE, 9'h0FE,
    9'h001
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int fails;
  int pending;
  int results;
  int pairs;
  int bad_marks;

  // Idling controls: gap_pct for the sender, stall_pct for the receiver, calm for both.
  int gap_pct;
  int stall_pct;
  bit calm;

  int items_sent;
  int streams_sent;
  int cycles;

  u16u32_in_if  utf16_ch ();
  u16u32_out_if utf32_ch ();

  utf16_to_utf32_stream_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (utf16_ch),
    .out_o  (utf32_ch)
  );

  utf16_to_utf32_stream_decoder_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (utf16_ch),
    .out_mon     (utf32_ch),
    .fails_o     (fails),
    .pending_o   (pending),
    .results_o   (results),
    .pairs_o     (pairs),
    .bad_marks_o (bad_marks)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d UTF-32 bytes outstanding",
               cycles, pending);
      $display("utf16_to_utf32_stream_decoder_tb: FAIL");
      $finish;
    end
  end

  // Receiver: ready stays high except in stall bursts of random length. The
  // burst is decided on the edge itself, so a stall can begin on any byte of
  // a four-byte code point, including its last one.
  initial begin
    int stall_left;
    stall_left = 0;
    utf32_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0)
        stall_left--;
      else if (!calm && $urandom_range(99) < stall_pct)
        stall_left = $urandom_range(18, 1);
      utf32_ch.ready <= (stall_left == 0);
    end
  end

  // Offers one byte and returns at the edge where its transfer happens. An
  // optional gap lowers valid first; when there is none, valid stays high
  // across back-to-back transfers. The ignored tail bytes of a bad stream are
  // sent with counts cleared so they do not count toward the random total.
  task automatic send_byte(input logic [7:0] b, input logic start, input bit counts);
    int gap;
    if (!calm && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(18, 1);
      utf16_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    utf16_ch.valid        <= 1'b1;
    utf16_ch.in_byte      <= b;
    utf16_ch.stream_start <= start;
    do @(posedge clk_i); while (!utf16_ch.ready);
    if (counts) items_sent++;
  endtask

  // Holds the sender off until every predicted UTF-32 byte has been seen. The
  // first edge is always waited out so that valid is not raised again in the
  // step where it was lowered, and so the last transfer is already predicted.
  task automatic wait_for_drain();
    utf16_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // A 16-bit code unit goes out high byte first in big endian streams.
  task automatic send_unit(input logic [15:0] u, input bit big);
    if (big) begin
      send_byte(u[15:8], 1'b0, 1'b1);
      send_byte(u[7:0], 1'b0, 1'b1);
    end else begin
      send_byte(u[7:0], 1'b0, 1'b1);
      send_byte(u[15:8], 1'b0, 1'b1);
    end
  endtask

  // A unit outside the surrogate range, with the range edges now and then.
  function automatic logic [15:0] plain_unit();
    logic [15:0] u;
    case ($urandom_range(9))
      0:       u = 16'h0000;
      1:       u = 16'hFFFF;
      2:       u = 16'hD7FF;
      3:       u = 16'hE000;
      4:       u = 16'($urandom_range(127));
      default: begin
        u = 16'($urandom);
        if (u inside {[16'hD800:16'hDFFF]}) u ^= 16'h8000;
      end
    endcase
    return u;
  endfunction

  function automatic logic [15:0] high_unit();
    case ($urandom_range(7))
      0:       return HiSurLo;
      1:       return HiSurHi;
      default: return HiSurLo | 16'($urandom_range(10'h3FF));
    endcase
  endfunction

  function automatic logic [15:0] low_unit();
    case ($urandom_range(7))
      0:       return LoSurLo;
      1:       return LoSurHi;
      default: return LoSurLo | 16'($urandom_range(10'h3FF));
    endcase
  endfunction

  // A stream with a valid mark and a random mix of units. Most units are
  // plain or proper surrogate pairs; the rest are unpaired high surrogates,
  // lone low surrogates and raw 16-bit noise. Some streams end on an odd
  // byte that the next stream start has to discard.
  task automatic send_good_stream();
    bit big;
    int n_units;
    int pick;
    big = 1'($urandom_range(1));
    streams_sent++;
    send_byte(big ? MarkFe : MarkFf, 1'b1, 1'b1);
    send_byte(big ? MarkFf : MarkFe, 1'b0, 1'b1);
    n_units = $urandom_range(12, 1);
    repeat (n_units) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        send_unit(plain_unit(), big);
      end else if (pick < 75) begin
        send_unit(high_unit(), big);
        send_unit(low_unit(), big);
      end else if (pick < 85) begin
        send_unit(high_unit(), big);
        send_unit(pick[0] ? high_unit() : plain_unit(), big);
      end else if (pick < 93) begin
        send_unit(low_unit(), big);
      end else begin
        send_unit(16'($urandom), big);
      end
    end
    if ($urandom_range(99) < 15) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  // A stream whose first two bytes are not a mark, then a few ignored bytes.
  // One of the two is often a mark byte so that near misses are common.
  task automatic send_bad_stream();
    logic [7:0] m0;
    logic [7:0] m1;
    int         n_tail;
    do begin
      m0 = $urandom_range(1) ? ($urandom_range(1) ? MarkFe : MarkFf) : 8'($urandom);
      m1 = $urandom_range(1) ? ($urandom_range(1) ? MarkFe : MarkFf) : 8'($urandom);
    end while ((m0 == MarkFe && m1 == MarkFf) || (m0 == MarkFf && m1 == MarkFe));
    streams_sent++;
    send_byte(m0, 1'b1, 1'b1);
    send_byte(m1, 1'b0, 1'b1);
    n_tail = $urandom_range(6);
    repeat (n_tail) send_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  // Raw bytes with stream starts at random places, including mid-pair.
  task automatic send_noise();
    int n;
    n = $urandom_range(8, 1);
    repeat (n) send_byte(8'($urandom), ($urandom_range(3) == 0), 1'b1);
  endtask

  initial begin
    int random_goal;
    int kind;
    utf16_ch.valid        <= 1'b0;
    utf16_ch.in_byte      <= 8'h00;
    utf16_ch.stream_start <= 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    calm      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with light idling on both sides.
    gap_pct   = 20;
    stall_pct = 20;
    foreach (DirectedSeq[i]) send_byte(DirectedSeq[i][7:0], DirectedSeq[i][8], 1'b1);
    streams_sent += 3;
    wait_for_drain();

    // Random part. The idling mix changes per stream, so there are stretches
    // with no idling, light idling and heavy idling on either side.
    random_goal = items_sent + RandomItems;
    while (items_sent < random_goal) begin
      if (items_sent >= random_goal - CalmTail) calm = 1'b1;
      case ($urandom_range(2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case ($urandom_range(2))
        0:       stall_pct = 0;
        1:       stall_pct = 15;
        default: stall_pct = 40;
      endcase
      kind = $urandom_range(99);
      if (kind < 78)      send_good_stream();
      else if (kind < 90) send_bad_stream();
      else                send_noise();
      if ($urandom_range(99) < 4) wait_for_drain();
    end

    // Let every predicted byte arrive, then watch a little longer for extras.
    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d UTF-16 bytes in %0d streams, %0d UTF-32 bytes checked.",
             items_sent, streams_sent, results);
    $display("Joined %0d surrogate pairs and saw %0d bad byte order marks.",
             pairs, bad_marks);
    if (fails == 0) begin
      $display("utf16_to_utf32_stream_decoder_tb: PASS");
    end else begin
      $display("%0d mismatches found", fails);
      $display("utf16_to_utf32_stream_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
